// ===== rtl/msi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// msi_pkg
// shared constants and types of the significant-inversion merge sorter
// ---------------------------------------------------------------------------
package msi_pkg;

	localparam int MAX_ELEMENTS = 32;
	localparam int DATA_W       = 32;
	localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
	localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
	localparam int SUM_W        = CNT_W + 2;
	localparam int LEN_W        = 6;
	localparam int COUNT_W      = 9;
	localparam int PADDR_W      = 3;
	localparam int APB_W        = 32;

	localparam logic             REG_LENGTH   = 1'b0;
	localparam logic [LEN_W-1:0] LENGTH_RESET = LEN_W'(32);

	typedef logic signed [DATA_W-1:0] word_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		word_t             wdata;
		logic [ADDR_W-1:0] raddr_a;
		logic [ADDR_W-1:0] raddr_b;
	} ram_ctl_t;

	typedef struct packed {
		logic  dbl;
		word_t lhs;
		word_t rhs;
	} cmp_req_t;

endpackage
`default_nettype wire

// ===== rtl/merge_sort_significant_inversions_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// merge_sort_significant_inversions_core
// loads a run of signed words, merge-sorts them and counts pairs i<j with
// a[i] > 2*a[j], then streams the sorted run out
// ---------------------------------------------------------------------------
// usage:
//  - apb register 0 (byte address 0) holds the run length, reset value 32;
//    0 acts as 1, values above 32 act as 32. write it only while idle
//  - a word is taken on a clock edge with start high and busy low; words
//    before the last of a run leave busy low
//  - the last word starts the sort: ceil(log2 n) passes, all through one
//    shared comparator and a pair of element memories, each with one
//    write port and two read ports
//  - then n results follow, each for one cycle with strobe high; every
//    result carries pair_count and the final one has last high; busy
//    drops in the cycle after the final result
//  - results cannot be held off, the receiver must take them as they come
//  - reset clears the sequencer, the load position and the count; the
//    memories hold no reset state and are written before they are read
// ---------------------------------------------------------------------------
module merge_sort_significant_inversions_core (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            psel,
	input  wire                            penable,
	input  wire                            pwrite,
	input  wire  [msi_pkg::PADDR_W-1:0]    paddr,
	input  wire  [msi_pkg::APB_W-1:0]      pwdata,
	output logic [msi_pkg::APB_W-1:0]      prdata,
	output logic                           pready,
	input  wire                            start,
	output logic                           busy,
	input  wire  signed [msi_pkg::DATA_W-1:0] value,
	output logic                           strobe,
	output logic signed [msi_pkg::DATA_W-1:0] sorted_value,
	output logic [msi_pkg::COUNT_W-1:0]    pair_count,
	output logic                           last
);
	import msi_pkg::*;

	logic [LEN_W-1:0] length_q;
	ram_ctl_t         mem0_ctl;
	ram_ctl_t         mem1_ctl;
	word_t            rd0_a;
	word_t            rd0_b;
	word_t            rd1_a;
	word_t            rd1_b;
	cmp_req_t         cmp_req;
	logic             cmp_lt;
	word_t            sorted_w;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= LENGTH_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_LENGTH)) begin
			length_q <= pwdata[LEN_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_LENGTH) ? APB_W'(length_q) : '0;

	msi_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.length       (length_q),
		.start        (start),
		.value        (value),
		.busy         (busy),
		.strobe       (strobe),
		.sorted_value (sorted_w),
		.pair_count   (pair_count),
		.last         (last),
		.mem0_ctl     (mem0_ctl),
		.mem1_ctl     (mem1_ctl),
		.rd0_a        (rd0_a),
		.rd0_b        (rd0_b),
		.rd1_a        (rd1_a),
		.rd1_b        (rd1_b),
		.cmp_req      (cmp_req),
		.cmp_lt       (cmp_lt)
	);

	msi_ram u_mem0 (
		.clk     (clk),
		.ctl     (mem0_ctl),
		.rdata_a (rd0_a),
		.rdata_b (rd0_b)
	);

	msi_ram u_mem1 (
		.clk     (clk),
		.ctl     (mem1_ctl),
		.rdata_a (rd1_a),
		.rdata_b (rd1_b)
	);

	msi_cmp u_cmp (
		.req (cmp_req),
		.lt  (cmp_lt)
	);

	assign sorted_value = sorted_w;

	// results only appear while a run is in flight
	assert property (@(posedge clk) disable iff (!arst_n) strobe |-> busy)
		else $error("result word outside a run");

	// a run only ends on its final word
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(strobe && last))
		else $error("run ended without a final word");

	// more words follow a word that is not the final one
	assert property (@(posedge clk) disable iff (!arst_n) (strobe && !last) |=> busy)
		else $error("run dropped before its final word");

	// a word just taken never shows up as a result in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> !strobe)
		else $error("result word directly after load");

endmodule
`default_nettype wire

// ===== rtl/msi_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// msi_ram
// element memory, one write port and two registered read ports
// ---------------------------------------------------------------------------
module msi_ram (
	input  wire              clk,
	input  msi_pkg::ram_ctl_t ctl,
	output msi_pkg::word_t    rdata_a,
	output msi_pkg::word_t    rdata_b
);
	import msi_pkg::*;

	word_t mem [MAX_ELEMENTS];

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[ctl.waddr] <= ctl.wdata;
		end
		rdata_a <= mem[ctl.raddr_a];
		rdata_b <= mem[ctl.raddr_b];
	end

endmodule
`default_nettype wire

// ===== rtl/msi_cmp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// msi_cmp
// shared 33-bit signed compare: plain less-than, or doubled right word
// ---------------------------------------------------------------------------
module msi_cmp (
	input  msi_pkg::cmp_req_t req,
	output logic              lt
);
	import msi_pkg::*;

	logic signed [DATA_W:0] x;
	logic signed [DATA_W:0] y;

	// doubled mode asks 2*rhs < lhs
	always_comb begin
		if (req.dbl) begin
			x = {req.rhs, 1'b0};
			y = {req.lhs[DATA_W-1], req.lhs};
		end else begin
			x = {req.lhs[DATA_W-1], req.lhs};
			y = {req.rhs[DATA_W-1], req.rhs};
		end
		lt = x < y;
	end

endmodule
`default_nettype wire

// ===== rtl/msi_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// msi_seq
// load, bottom-up merge passes with inversion counting, and word output
// ---------------------------------------------------------------------------
module msi_seq (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire  [msi_pkg::LEN_W-1:0]     length,
	input  wire                           start,
	input  msi_pkg::word_t                value,
	output logic                          busy,
	output logic                          strobe,
	output msi_pkg::word_t                sorted_value,
	output logic [msi_pkg::COUNT_W-1:0]   pair_count,
	output logic                          last,
	output msi_pkg::ram_ctl_t             mem0_ctl,
	output msi_pkg::ram_ctl_t             mem1_ctl,
	input  msi_pkg::word_t                rd0_a,
	input  msi_pkg::word_t                rd0_b,
	input  msi_pkg::word_t                rd1_a,
	input  msi_pkg::word_t                rd1_b,
	output msi_pkg::cmp_req_t             cmp_req,
	input  wire                           cmp_lt
);
	import msi_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CNT  = 2'd1;
	localparam logic [1:0] ST_MRG  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]         state_q;
	logic               ph_q;
	logic               src_q;
	logic [CNT_W-1:0]   load_q;
	logic [CNT_W-1:0]   n_q;
	logic [CNT_W-1:0]   width_q;
	logic [CNT_W-1:0]   lo_q;
	logic [CNT_W-1:0]   mid_q;
	logic [CNT_W-1:0]   hi_q;
	logic [CNT_W-1:0]   i_q;
	logic [CNT_W-1:0]   j_q;
	logic [CNT_W-1:0]   k_q;
	logic [COUNT_W-1:0] total_q;

	logic [CNT_W-1:0]   eff_len;
	logic [CNT_W-1:0]   ld_idx;
	logic [CNT_W-1:0]   ld_next;
	logic               accept;
	word_t              a_w;
	word_t              b_w;
	logic               take_left;
	word_t              merge_w;
	logic [SUM_W-1:0]   seg_end;
	logic [SUM_W-1:0]   w2;
	logic [CNT_W-1:0]   nx_mid;
	logic [CNT_W-1:0]   nx_hi;
	logic [CNT_W-1:0]   p_mid;
	logic [CNT_W-1:0]   p_hi;
	logic [CNT_W-1:0]   i_mid;
	logic [CNT_W-1:0]   i_hi;
	logic [COUNT_W:0]   sum_w;

	function automatic logic [CNT_W-1:0] clip(input logic [SUM_W-1:0] x,
			input logic [CNT_W-1:0] n);
		return (x > SUM_W'(n)) ? n : CNT_W'(x);
	endfunction

	always_comb begin
		if (length == '0) begin
			eff_len = CNT_W'(1);
		end else if (int'(length) > MAX_ELEMENTS) begin
			eff_len = CNT_W'(MAX_ELEMENTS);
		end else begin
			eff_len = CNT_W'(length);
		end
		ld_idx  = (int'(load_q) >= MAX_ELEMENTS) ? '0 : load_q;
		ld_next = ld_idx + CNT_W'(1);
	end

	assign accept    = start && (state_q == ST_IDLE);
	assign a_w       = src_q ? rd1_a : rd0_a;
	assign b_w       = src_q ? rd1_b : rd0_b;
	assign take_left = (j_q >= hi_q) || ((i_q < mid_q) && cmp_lt);
	assign merge_w   = take_left ? a_w : b_w;

	assign seg_end = SUM_W'(lo_q) + SUM_W'(width_q) + SUM_W'(width_q);
	assign w2      = SUM_W'(width_q) + SUM_W'(width_q);
	assign nx_mid  = clip(seg_end + SUM_W'(width_q), n_q);
	assign nx_hi   = clip(seg_end + w2, n_q);
	assign p_mid   = clip(w2, n_q);
	assign p_hi    = clip(w2 + w2, n_q);
	assign i_mid   = clip(SUM_W'(1), ld_next);
	assign i_hi    = clip(SUM_W'(2), ld_next);
	assign sum_w   = (COUNT_W+1)'(total_q) + (COUNT_W+1)'(j_q - mid_q);

	assign cmp_req.dbl = (state_q == ST_CNT);
	assign cmp_req.lhs = a_w;
	assign cmp_req.rhs = b_w;

	always_comb begin
		mem0_ctl.raddr_a = i_q[ADDR_W-1:0];
		mem0_ctl.raddr_b = j_q[ADDR_W-1:0];
		mem1_ctl.raddr_a = i_q[ADDR_W-1:0];
		mem1_ctl.raddr_b = j_q[ADDR_W-1:0];
		mem1_ctl.we      = (state_q == ST_MRG) && ph_q && !src_q;
		mem1_ctl.waddr   = k_q[ADDR_W-1:0];
		mem1_ctl.wdata   = merge_w;
		if (accept) begin
			mem0_ctl.we    = 1'b1;
			mem0_ctl.waddr = ld_idx[ADDR_W-1:0];
			mem0_ctl.wdata = value;
		end else begin
			mem0_ctl.we    = (state_q == ST_MRG) && ph_q && src_q;
			mem0_ctl.waddr = k_q[ADDR_W-1:0];
			mem0_ctl.wdata = merge_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ph_q    <= 1'b0;
			src_q   <= 1'b0;
			load_q  <= '0;
			total_q <= '0;
			n_q     <= '0;
			width_q <= '0;
			lo_q    <= '0;
			mid_q   <= '0;
			hi_q    <= '0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					ph_q <= 1'b0;
					if (accept) begin
						if (ld_next >= eff_len) begin
							load_q  <= '0;
							n_q     <= ld_next;
							total_q <= '0;
							src_q   <= 1'b0;
							width_q <= CNT_W'(1);
							lo_q    <= '0;
							i_q     <= '0;
							k_q     <= '0;
							mid_q   <= i_mid;
							j_q     <= i_mid;
							hi_q    <= i_hi;
							state_q <= (ld_next == CNT_W'(1)) ? ST_OUT : ST_CNT;
						end else begin
							load_q <= ld_next;
						end
					end
				end
				ST_CNT: begin
					if (!ph_q) begin
						if (i_q == mid_q) begin
							i_q     <= lo_q;
							j_q     <= mid_q;
							k_q     <= lo_q;
							state_q <= ST_MRG;
						end else begin
							ph_q <= 1'b1;
						end
					end else begin
						ph_q <= 1'b0;
						if ((j_q < hi_q) && cmp_lt) begin
							j_q <= j_q + CNT_W'(1);
						end else begin
							total_q <= sum_w[COUNT_W] ? '1 : sum_w[COUNT_W-1:0];
							i_q     <= i_q + CNT_W'(1);
						end
					end
				end
				ST_MRG: begin
					if (!ph_q) begin
						if (k_q == hi_q) begin
							if (seg_end < SUM_W'(n_q)) begin
								// next pair of runs in this pass
								lo_q    <= CNT_W'(seg_end);
								i_q     <= CNT_W'(seg_end);
								mid_q   <= nx_mid;
								j_q     <= nx_mid;
								hi_q    <= nx_hi;
								state_q <= ST_CNT;
							end else if (w2 < SUM_W'(n_q)) begin
								// next pass, runs twice as long
								src_q   <= !src_q;
								width_q <= CNT_W'(w2);
								lo_q    <= '0;
								i_q     <= '0;
								mid_q   <= p_mid;
								j_q     <= p_mid;
								hi_q    <= p_hi;
								state_q <= ST_CNT;
							end else begin
								src_q   <= !src_q;
								i_q     <= '0;
								state_q <= ST_OUT;
							end
						end else begin
							ph_q <= 1'b1;
						end
					end else begin
						ph_q <= 1'b0;
						k_q  <= k_q + CNT_W'(1);
						if (take_left) begin
							i_q <= i_q + CNT_W'(1);
						end else begin
							j_q <= j_q + CNT_W'(1);
						end
					end
				end
				ST_OUT: begin
					if (!ph_q) begin
						ph_q <= 1'b1;
					end else begin
						ph_q <= 1'b0;
						if (i_q == n_q - CNT_W'(1)) begin
							state_q <= ST_IDLE;
						end else begin
							i_q <= i_q + CNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ph_q    <= 1'b0;
				end
			endcase
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign strobe       = (state_q == ST_OUT) && ph_q;
	assign sorted_value = a_w;
	assign pair_count   = total_q;
	assign last         = strobe && (i_q == n_q - CNT_W'(1));

endmodule
`default_nettype wire
